// ===== rtl/sa_pkg.sv =====
package sa_pkg;

  localparam int unsigned MaxPatternLen = 4096;
  localparam int unsigned AlphabetSize  = 26;
  localparam int unsigned MaxNodes      = 2 * MaxPatternLen;
  localparam int unsigned NodeW         = $clog2(MaxNodes);
  localparam int unsigned CountW        = NodeW + 1;
  localparam int unsigned LenW          = 13;
  localparam int unsigned PosW          = 16;
  localparam int unsigned SymW          = 5;

  typedef logic [NodeW-1:0]  node_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [LenW-1:0]   len_t;
  typedef logic [PosW-1:0]   pos_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  localparam logic ReqPattern = 1'b0;

  // One outgoing transition: valid flag and target node
  typedef struct packed {
    logic  ok;
    node_t to;
  } trans_ent_t;

  typedef trans_ent_t [AlphabetSize-1:0] trans_row_t;

  typedef struct packed {
    node_t link;
    len_t  len;
  } node_ent_t;

  typedef struct packed {
    logic            req_type;
    logic [SymW-1:0] symbol;
    logic            text_start;
  } req_t;

  typedef struct packed {
    status_e status;
    count_t  node_count;
    len_t    match_len;
    len_t    best_len;
    pos_t    best_end;
  } res_t;

endpackage

// ===== rtl/sa_engine.sv =====
module sa_engine import sa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  input  logic take_i,
  output logic busy_o,
  output logic done_o,
  output res_t res_o
);

  typedef enum logic [2:0] {
    IDLE, E_WALK, E_QCHK, E_LINKQ, E_LINKNL, E_REDIR, S_WALK, DONE
  } state_e;

  state_e state_q, state_d;

  // Transition rows, one row per node
  trans_row_t trans_mem [MaxNodes];
  trans_row_t trans_rd_q, trans_wd;
  logic       trans_we;
  node_t      trans_wa;

  // Suffix link and length per node
  node_ent_t node_mem [MaxNodes];
  node_ent_t node_rd_q, node_wd;
  logic      node_we;
  node_t     node_wa;

  node_t rd_addr, rd_addr_q;

  logic            root_init_q, root_init_d;
  logic [SymW-1:0] sym_q, sym_d;
  node_t           nl_q, nl_d, q_q, q_d, r_q, r_d, p_q, p_d;
  len_t            nl_len_q, nl_len_d, len_p_q, len_p_d, len_q_q, len_q_d;
  node_t           last_node_q, last_node_d, scan_node_q, scan_node_d;
  len_t            last_len_q, last_len_d, scan_len_q, scan_len_d;
  len_t            best_len_q, best_len_d;
  pos_t            best_end_q, best_end_d, pos_q, pos_d;
  count_t          nodes_used_q, nodes_used_d;
  logic            moved_q, moved_d;
  res_t            res_q, res_d;

  trans_row_t row_cur, row_upd;
  trans_ent_t ent_cur, ent_new;
  len_t       len_cur, len_eff, sz;
  node_t      link_cur, fin;

  always_ff @(posedge clk_i) begin
    if (trans_we) begin
      trans_mem[trans_wa] <= trans_wd;
    end
    if (trans_we && trans_wa == rd_addr) begin
      trans_rd_q <= trans_wd;
    end else begin
      trans_rd_q <= trans_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_we && node_wa == rd_addr) begin
      node_rd_q <= node_wd;
    end else begin
      node_rd_q <= node_mem[rd_addr];
    end
  end

  // Root row reads empty until first written; root length is always zero
  assign row_cur  = (rd_addr_q == '0 && !root_init_q) ? '0 : trans_rd_q;
  assign ent_cur  = row_cur[sym_q];
  assign len_cur  = (rd_addr_q == '0) ? '0 : node_rd_q.len;
  assign link_cur = node_rd_q.link;
  assign ent_new  = '{ok: 1'b1, to: (state_q == E_REDIR) ? r_q : nl_q};
  assign len_eff  = moved_q ? len_cur : scan_len_q;
  assign sz       = ent_cur.ok ? len_eff + LenW'(1) : len_eff;
  assign fin      = ent_cur.ok ? ent_cur.to : rd_addr_q;

  always_comb begin
    row_upd          = row_cur;
    row_upd[sym_q]   = ent_new;
  end

  always_comb begin
    state_d      = state_q;
    rd_addr      = rd_addr_q;
    trans_we     = 1'b0;
    trans_wa     = rd_addr_q;
    trans_wd     = row_upd;
    node_we      = 1'b0;
    node_wa      = nl_q;
    node_wd      = '0;
    sym_d        = sym_q;
    nl_d         = nl_q;
    q_d          = q_q;
    r_d          = r_q;
    p_d          = p_q;
    nl_len_d     = nl_len_q;
    len_p_d      = len_p_q;
    len_q_d      = len_q_q;
    last_node_d  = last_node_q;
    last_len_d   = last_len_q;
    scan_node_d  = scan_node_q;
    scan_len_d   = scan_len_q;
    best_len_d   = best_len_q;
    best_end_d   = best_end_q;
    pos_d        = pos_q;
    nodes_used_d = nodes_used_q;
    moved_d      = moved_q;
    res_d        = res_q;
    root_init_d  = root_init_q;

    case (state_q)
      IDLE: begin
        if (start_i) begin
          sym_d = req_i.symbol;
          res_d = '{status: ST_OK, node_count: nodes_used_q, match_len: '0,
                    best_len: best_len_q, best_end: best_end_q};
          if (req_i.symbol >= SymW'(AlphabetSize)) begin
            res_d.status = ST_BAD;
            state_d      = DONE;
          end else if (req_i.req_type == ReqPattern) begin
            if (last_len_q >= LenW'(MaxPatternLen) ||
                {1'b0, nodes_used_q} + (CountW+1)'(2) > (CountW+1)'(MaxNodes)) begin
              res_d.status = ST_FULL;
              state_d      = DONE;
            end else begin
              // allocate the new node and clear its row
              nl_d         = nodes_used_q[NodeW-1:0];
              nodes_used_d = nodes_used_q + CountW'(1);
              nl_len_d     = last_len_q + LenW'(1);
              trans_we     = 1'b1;
              trans_wa     = nodes_used_q[NodeW-1:0];
              trans_wd     = '0;
              rd_addr      = last_node_q;
              last_node_d  = nodes_used_q[NodeW-1:0];
              last_len_d   = last_len_q + LenW'(1);
              state_d      = E_WALK;
            end
          end else begin
            moved_d = 1'b0;
            if (req_i.text_start) begin
              scan_node_d = '0;
              scan_len_d  = '0;
              best_len_d  = '0;
              best_end_d  = '0;
              pos_d       = '0;
              rd_addr     = '0;
            end else begin
              rd_addr = scan_node_q;
            end
            state_d = S_WALK;
          end
        end
      end
      E_WALK: begin
        if (ent_cur.ok) begin
          q_d     = ent_cur.to;
          len_p_d = len_cur;
          p_d     = rd_addr_q;
          rd_addr = ent_cur.to;
          state_d = E_QCHK;
        end else begin
          trans_we = 1'b1;
          if (rd_addr_q == '0) begin
            node_we = 1'b1;
            node_wd = '{link: '0, len: nl_len_q};
            res_d.node_count = nodes_used_q;
            state_d = DONE;
          end else begin
            rd_addr = link_cur;
          end
        end
      end
      E_QCHK: begin
        if (len_cur == len_p_q + LenW'(1)) begin
          node_we = 1'b1;
          node_wd = '{link: q_q, len: nl_len_q};
          res_d.node_count = nodes_used_q;
          state_d = DONE;
        end else begin
          // clone q into r
          r_d          = nodes_used_q[NodeW-1:0];
          nodes_used_d = nodes_used_q + CountW'(1);
          trans_we     = 1'b1;
          trans_wa     = nodes_used_q[NodeW-1:0];
          trans_wd     = row_cur;
          node_we      = 1'b1;
          node_wa      = nodes_used_q[NodeW-1:0];
          node_wd      = '{link: link_cur, len: len_p_q + LenW'(1)};
          len_q_d      = len_cur;
          state_d      = E_LINKQ;
        end
      end
      E_LINKQ: begin
        node_we = 1'b1;
        node_wa = q_q;
        node_wd = '{link: r_q, len: len_q_q};
        state_d = E_LINKNL;
      end
      E_LINKNL: begin
        node_we = 1'b1;
        node_wd = '{link: r_q, len: nl_len_q};
        rd_addr = p_q;
        state_d = E_REDIR;
      end
      E_REDIR: begin
        res_d.node_count = nodes_used_q;
        if (ent_cur.ok && ent_cur.to == q_q) begin
          trans_we = 1'b1;
          if (rd_addr_q == '0) begin
            state_d = DONE;
          end else begin
            rd_addr = link_cur;
          end
        end else begin
          state_d = DONE;
        end
      end
      S_WALK: begin
        if (rd_addr_q != '0 && !ent_cur.ok) begin
          rd_addr = link_cur;
          moved_d = 1'b1;
        end else begin
          scan_node_d = fin;
          scan_len_d  = sz;
          if (sz > best_len_q) begin
            best_len_d = sz;
            best_end_d = pos_q;
          end
          pos_d   = pos_q + PosW'(1);
          res_d   = '{status: ST_OK, node_count: nodes_used_q, match_len: sz,
                      best_len: (sz > best_len_q) ? sz : best_len_q,
                      best_end: (sz > best_len_q) ? pos_q : best_end_q};
          state_d = DONE;
        end
      end
      DONE: begin
        if (take_i) begin
          state_d = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase

    if (trans_we && trans_wa == '0) begin
      root_init_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      rd_addr_q    <= '0;
      root_init_q  <= 1'b0;
      sym_q        <= '0;
      nl_q         <= '0;
      q_q          <= '0;
      r_q          <= '0;
      p_q          <= '0;
      nl_len_q     <= '0;
      len_p_q      <= '0;
      len_q_q      <= '0;
      last_node_q  <= '0;
      last_len_q   <= '0;
      scan_node_q  <= '0;
      scan_len_q   <= '0;
      best_len_q   <= '0;
      best_end_q   <= '0;
      pos_q        <= '0;
      nodes_used_q <= CountW'(1);
      moved_q      <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      rd_addr_q    <= rd_addr;
      root_init_q  <= root_init_d;
      sym_q        <= sym_d;
      nl_q         <= nl_d;
      q_q          <= q_d;
      r_q          <= r_d;
      p_q          <= p_d;
      nl_len_q     <= nl_len_d;
      len_p_q      <= len_p_d;
      len_q_q      <= len_q_d;
      last_node_q  <= last_node_d;
      last_len_q   <= last_len_d;
      scan_node_q  <= scan_node_d;
      scan_len_q   <= scan_len_d;
      best_len_q   <= best_len_d;
      best_end_q   <= best_end_d;
      pos_q        <= pos_d;
      nodes_used_q <= nodes_used_d;
      moved_q      <= moved_d;
      res_q        <= res_d;
    end
  end

  assign busy_o = (state_q != IDLE);
  assign done_o = (state_q == DONE);
  assign res_o  = res_q;

endmodule

// ===== rtl/suffix_automaton_common_substring.sv =====
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_stall_o | in_req_type_i, in_symbol_i, in_text_start_i
// out     | output    | out_valid_o/out_stall_i | out_status_o, out_node_count_o,
//         |           |                       | out_match_len_o, out_best_len_o,
//         |           |                       | out_best_start_o, out_best_end_o
//
// One transaction in flight at a time. A bad or refused item goes straight to the
// result after acceptance; a text symbol takes one step per suffix-link
// fallback; a pattern symbol takes one step per link walked, one more when the
// walk meets an existing transition, and, when a node is cloned, links q and the
// new node and then takes one step per redirect. Every step is one read of the
// transition-row and node memories (registered reads).
// Reset clears control state only; no memory clearing pass is needed.
// in_stall_o is high while an item is in work or its result waits for the
// output register; the output register frees the engine as soon as it loads.
module suffix_automaton_common_substring import sa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            in_req_type_i,
  input  logic [SymW-1:0] in_symbol_i,
  input  logic            in_text_start_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      out_status_o,
  output logic [13:0]     out_node_count_o,
  output logic [12:0]     out_match_len_o,
  output logic [12:0]     out_best_len_o,
  output logic [15:0]     out_best_start_o,
  output logic [15:0]     out_best_end_o
);

  logic busy, done, take, start;
  req_t req;
  res_t res;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q;
  count_t      count_q;
  len_t        match_q, best_len_q;
  pos_t        best_start_q, best_end_q;
  pos_t        start_pos;

  assign req   = '{req_type: in_req_type_i, symbol: in_symbol_i,
                   text_start: in_text_start_i};
  assign start = in_valid_i && !in_stall_o;

  // Load the result register whenever it is empty or being drained
  assign take = done && (!out_valid_q || !out_stall_i);

  sa_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req),
    .take_i  (take),
    .busy_o  (busy),
    .done_o  (done),
    .res_o   (res)
  );

  // Start position of the best match: end minus length plus one, mod 2^16
  assign start_pos = res.best_end - PosW'(res.best_len) + PosW'(1);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q   <= res.status;
      count_q    <= res.node_count;
      match_q    <= res.match_len;
      best_len_q <= res.best_len;
      // hold positions at zero until a match exists
      if (res.best_len == '0) begin
        best_start_q <= '0;
        best_end_q   <= '0;
      end else begin
        best_start_q <= start_pos;
        best_end_q   <= res.best_end;
      end
    end
  end

  assign in_stall_o       = busy;
  assign out_valid_o      = out_valid_q;
  assign out_status_o     = status_q;
  assign out_node_count_o = count_q;
  assign out_match_len_o  = match_q;
  assign out_best_len_o   = best_len_q;
  assign out_best_start_o = best_start_q;
  assign out_best_end_o   = best_end_q;

`ifndef SYNTHESIS
  a_ignored_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o != ST_OK |-> out_match_len_o == '0)
    else $error("ignored item reports a match length");

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("result register did not load");

  a_nodes_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_node_count_o != '0)
    else $error("node count is zero");
`endif

endmodule

// ===== dv/suffix_automaton_common_substring_tb.sv =====
module suffix_automaton_common_substring_tb;
  import sa_pkg::*;

  // Watchdog limit, far above the longest stalled run of the stimulus.
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned DrainWait  = 64;
  localparam logic        ReqText    = ~ReqPattern;

  // Letters with a fixed role in the stimulus.
  localparam logic [SymW-1:0] SymA    = 5'd0;
  localparam logic [SymW-1:0] SymB    = 5'd1;
  localparam logic [SymW-1:0] SymY    = 5'd24;  // never put in the pattern
  localparam logic [SymW-1:0] SymZ    = 5'd25;
  localparam logic [SymW-1:0] SymBad  = 5'd26;
  localparam logic [SymW-1:0] SymMax  = 5'd31;

  typedef struct {
    status_e     status;
    count_t      node_count;
    len_t        match_len;
    len_t        best_len;
    pos_t        best_start;
    pos_t        best_end;
  } lcs_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            in_req_type_i = 1'b0;
  logic [SymW-1:0] in_symbol_i = '0;
  logic            in_text_start_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [1:0]      out_status_o;
  logic [13:0]     out_node_count_o;
  logic [12:0]     out_match_len_o;
  logic [12:0]     out_best_len_o;
  logic [15:0]     out_best_start_o;
  logic [15:0]     out_best_end_o;

  suffix_automaton_common_substring u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_req_type_i   (in_req_type_i),
    .in_symbol_i     (in_symbol_i),
    .in_text_start_i (in_text_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_status_o    (out_status_o),
    .out_node_count_o(out_node_count_o),
    .out_match_len_o (out_match_len_o),
    .out_best_len_o  (out_best_len_o),
    .out_best_start_o(out_best_start_o),
    .out_best_end_o  (out_best_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow automaton: own copy of the transition table, links and lengths.
  // ---------------------------------------------------------------------------
  bit          edge_ok   [MaxNodes][AlphabetSize];
  int unsigned edge_to   [MaxNodes][AlphabetSize];
  int unsigned link_of   [MaxNodes];
  int unsigned depth_of  [MaxNodes];
  int unsigned tail_node   = 0;
  int unsigned nodes_alloc = 1;
  int unsigned cur_state   = 0;
  int unsigned cur_len     = 0;
  int unsigned longest_len = 0;
  int unsigned longest_end = 0;
  int unsigned text_pos    = 0;

  // Append one letter to the automaton: new node, optional clone, link fixups.
  function automatic void append_letter(int unsigned c);
    int unsigned nl;
    int unsigned p;
    int unsigned q;
    int unsigned r;
    bit          found;
    nl = nodes_alloc;
    nodes_alloc++;
    p = tail_node;
    found = 1'b0;
    for (int k = 0; k < AlphabetSize; k++) edge_ok[nl][k] = 1'b0;
    depth_of[nl] = depth_of[tail_node] + 1;
    forever begin
      if (edge_ok[p][c]) begin
        found = 1'b1;
        break;
      end
      edge_ok[p][c] = 1'b1;
      edge_to[p][c] = nl;
      if (p == 0) break;
      p = link_of[p] % MaxNodes;
    end
    if (!found) begin
      link_of[nl] = 0;
    end else begin
      q = edge_to[p][c] % MaxNodes;
      if (depth_of[q] == depth_of[p] + 1) begin
        link_of[nl] = q;
      end else begin
        // Split q: the clone takes q's edges and the shorter length.
        r = nodes_alloc;
        nodes_alloc++;
        for (int k = 0; k < AlphabetSize; k++) begin
          edge_to[r][k] = edge_to[q][k];
          edge_ok[r][k] = edge_ok[q][k];
        end
        depth_of[r] = depth_of[p] + 1;
        link_of[r]  = link_of[q];
        link_of[q]  = r;
        link_of[nl] = r;
        forever begin
          if (!(edge_ok[p][c] && edge_to[p][c] == q)) break;
          edge_to[p][c] = r;
          if (p == 0) break;
          p = link_of[p] % MaxNodes;
        end
      end
    end
    tail_node = nl;
  endfunction

  // Advance the text scan by one letter, falling back along links on a miss.
  function automatic void scan_letter(int unsigned c);
    int unsigned node;
    int unsigned sz;
    int unsigned guard;
    node = cur_state % MaxNodes;
    sz = cur_len;
    guard = 0;
    while (node != 0 && !edge_ok[node][c] && guard < MaxNodes) begin
      node = link_of[node] % MaxNodes;
      sz = depth_of[node];
      guard++;
    end
    if (edge_ok[node][c]) begin
      node = edge_to[node][c] % MaxNodes;
      sz++;
    end
    cur_state = node;
    cur_len = sz;
    if (sz > longest_len) begin
      longest_len = sz;
      longest_end = text_pos;
    end
    text_pos = (text_pos + 1) & 16'hFFFF;
  endfunction

  function automatic lcs_result_t step_automaton(req_t r);
    lcs_result_t res;
    res.status = ST_OK;
    res.match_len = '0;
    res.best_start = '0;
    res.best_end = '0;
    if (r.symbol >= AlphabetSize) begin
      res.status = ST_BAD;
    end else if (r.req_type == ReqPattern) begin
      if (depth_of[tail_node % MaxNodes] >= MaxPatternLen || nodes_alloc + 2 > MaxNodes)
        res.status = ST_FULL;
      else
        append_letter(r.symbol);
    end else begin
      if (r.text_start) begin
        cur_state = 0;
        cur_len = 0;
        longest_len = 0;
        longest_end = 0;
        text_pos = 0;
      end
      scan_letter(r.symbol);
      res.match_len = len_t'(cur_len);
    end
    if (longest_len > 0) begin
      res.best_end = pos_t'(longest_end);
      res.best_start = pos_t'(longest_end - longest_len + 1);
    end
    res.node_count = count_t'(nodes_alloc);
    res.best_len = len_t'(longest_len);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, monitor and watchdog
  // ---------------------------------------------------------------------------
  req_t        pending_reqs[$];
  lcs_result_t expected_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_output = 1'b0;
  int unsigned hold_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  req_t        next_req;

  // Predict on acceptance, then advance to the next transaction or hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(step_automaton(
            '{req_type: in_req_type_i, symbol: in_symbol_i, text_start: in_text_start_i}));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_req_type_i   <= next_req.req_type;
          in_symbol_i     <= next_req.symbol;
          in_text_start_i <= next_req.text_start;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lcs_result_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, out_status_o);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", exp_res.status, out_status_o);
          check_field("node_count", exp_res.node_count, out_node_count_o);
          check_field("match_len", exp_res.match_len, out_match_len_o);
          check_field("best_len", exp_res.best_len, out_best_len_o);
          check_field("best_start", exp_res.best_start, out_best_start_o);
          check_field("best_end", exp_res.best_end, out_best_end_o);
        end
      end
      // Long hold-off: keep the output blocked so the engine backs up.
      if (hold_output && hold_count < LongHold) begin
        hold_count <= hold_count + 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_req(logic req_type, logic [SymW-1:0] sym, logic ts);
    pending_reqs.push_back('{req_type: req_type, symbol: sym, text_start: ts});
  endtask

  // Pattern letters: small alphabet for deep matches, never the letter Y.
  function automatic logic [SymW-1:0] pattern_letter();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return SymW'($urandom_range(3));
    if (pick < 95) return SymW'($urandom_range(23));
    return SymZ;
  endfunction

  // Random runs of pattern letters or text letters, mostly text, some noise mixed in.
  task automatic add_random(int unsigned count);
    int unsigned pick;
    int unsigned run;
    int unsigned added;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(99);
      run = $urandom_range(12, 1);
      for (int unsigned k = 0; k < run; k++) begin
        if (pick < 30) begin
          add_req(ReqPattern, pattern_letter(), 1'($urandom_range(1)));
        end else if (pick < 92) begin
          add_req(ReqText, ($urandom_range(99) < 85) ? SymW'($urandom_range(4))
                                                    : SymW'($urandom_range(25)),
                  ($urandom_range(99) < 3));
        end else begin
          add_req(1'($urandom_range(1)), SymW'($urandom_range(31, 26)),
                  1'($urandom_range(1)));
        end
      end
      added += run;
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned count);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    add_random(count);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: no best yet, clones, fallbacks, bad symbols, pattern after text.
    add_req(ReqText, SymY, 1'b1);
    add_req(ReqPattern, SymA, 1'b0);
    add_req(ReqPattern, SymB, 1'b1);
    add_req(ReqPattern, SymB, 1'b0);
    add_req(ReqPattern, SymA, 1'b0);
    add_req(ReqPattern, SymB, 1'b0);
    add_req(ReqPattern, SymZ, 1'b0);
    add_req(ReqText, SymA, 1'b1);
    add_req(ReqText, SymB, 1'b0);
    add_req(ReqText, SymB, 1'b0);
    add_req(ReqText, SymA, 1'b0);
    add_req(ReqText, SymY, 1'b0);
    add_req(ReqText, SymB, 1'b0);
    add_req(ReqText, SymBad, 1'b1);
    add_req(ReqPattern, SymMax, 1'b1);
    add_req(ReqText, SymZ, 1'b0);
    add_req(ReqPattern, SymA, 1'b0);
    add_req(ReqText, SymA, 1'b0);
    add_req(ReqText, SymMax, 1'b0);
    add_req(ReqText, SymB, 1'b1);
    drain();

    // Random phases: no idling (with one long output hold), sender idle,
    // receiver stalling, both.
    hold_output = 1'b1;
    run_phase(0, 0, 470);
    hold_output = 1'b0;
    run_phase(86, 0, 460);
    run_phase(0, 86, 460);
    run_phase(23, 23, 460);

    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== suffix_automaton_common_substring.f =====
rtl/sa_pkg.sv
rtl/sa_engine.sv
rtl/suffix_automaton_common_substring.sv
dv/suffix_automaton_common_substring_tb.sv
